/* hw/rtl/stt3d_pkg.sv */
// Package for the segment versus triangle front-face test.
// Holds stream widths, pipeline depth and the cross-product index tables.
// No dependencies.
`timescale 1ns / 1ps

package stt3d_pkg;

  // One input beat carries five packed points of three coordinates each.
  localparam int unsigned FIELD_W      = 48;
  localparam int unsigned NUM_POINTS   = 5;
  localparam int unsigned IN_TDATA_W   = FIELD_W * NUM_POINTS;
  localparam int unsigned OUT_TDATA_W  = 8;

  // Register stages from input to output register.
  localparam int unsigned NUM_STAGES   = 6;

  // Point slots inside in_tdata.
  localparam int unsigned SLOT_V1      = 0;
  localparam int unsigned SLOT_V2      = 1;
  localparam int unsigned SLOT_V3      = 2;
  localparam int unsigned SLOT_START   = 3;
  localparam int unsigned SLOT_END     = 4;

  // Cross product r = a x b: r[i] = a[NEXT1[i]] * b[NEXT2[i]] - a[NEXT2[i]] * b[NEXT1[i]].
  localparam int unsigned NEXT1 [3] = '{1, 2, 0};
  localparam int unsigned NEXT2 [3] = '{2, 0, 1};

endpackage

/* hw/rtl/segment_triangle_3d_test.sv */
// Segment versus triangle front-face intersection test, six-stage pipeline.
// Depends on stt3d_pkg (widths, stage count, cross-product index tables).
`timescale 1ns / 1ps

// Usage
//   Input channel (in_*): one beat per query. in_tdata packs five 48-bit points,
//   lowest first: vertex_one, vertex_two, vertex_three, segment_start,
//   segment_end. Each point holds signed x, y, z of COORD_WIDTH bits, x lowest;
//   point bits above 3*COORD_WIDTH are ignored, missing top z bits read as zero.
//   Output channel (out_*): one beat per query, in order; out_tdata[0] is hit.
//   Hit means the segment reaches the front face (inclusive of edges, vertices
//   and end points on the plane); degenerate triangles and back faces miss.
// Depth and throughput
//   Six register stages. One beat per cycle is sustained while out_tready stays
//   high; the depth is set by the two cross/dot multiply ranks, each followed
//   by a register.
// Stall and reset
//   The whole pipeline advances together when the output register is empty or
//   being taken. While out_tready is low with a result held, every stage holds
//   and in_tready drops; no beat is lost or repeated. Synchronous reset
//   (rst_n low) empties every stage; there is no other state.
module segment_triangle_3d_test #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: vertex_one[47:0], vertex_two, vertex_three, segment_start,
  //           segment_end[239:192]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [stt3d_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: hit[0], zero pad[7:1]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [stt3d_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  import stt3d_pkg::*;

  // Exact widths: coordinate, difference, product of differences,
  // cross-product component, dot-product term and three-term sum.
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned DW   = CW + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned NW   = PW + 1;
  localparam int unsigned MW   = DW + NW;
  localparam int unsigned SW   = MW + 2;
  localparam int unsigned PADW = (3 * CW > FIELD_W) ? 3 * CW : FIELD_W;

  logic                   pipe_en;
  logic [NUM_STAGES-1:0]  vld_r;

  // Stage 1: edge and segment differences.
  logic signed [CW-1:0]   pt   [NUM_POINTS][3];
  logic signed [DW-1:0]   ab_nxt [3];
  logic signed [DW-1:0]   ac_nxt [3];
  logic signed [DW-1:0]   pq_nxt [3];
  logic signed [DW-1:0]   ap_nxt [3];
  logic signed [DW-1:0]   ab1_r  [3];
  logic signed [DW-1:0]   ac1_r  [3];
  logic signed [DW-1:0]   pq1_r  [3];
  logic signed [DW-1:0]   ap1_r  [3];

  // Stage 2: cross-product partial products, differences carried.
  logic signed [PW-1:0]   npa_r [3];
  logic signed [PW-1:0]   npb_r [3];
  logic signed [PW-1:0]   qpa_r [3];
  logic signed [PW-1:0]   qpb_r [3];
  logic signed [DW-1:0]   ab2_r [3];
  logic signed [DW-1:0]   ac2_r [3];
  logic signed [DW-1:0]   pq2_r [3];
  logic signed [DW-1:0]   ap2_r [3];

  // Stage 3: normal n = ab x ac and q = pq x ap.
  logic signed [NW-1:0]   n3_r  [3];
  logic signed [NW-1:0]   q3_r  [3];
  logic signed [DW-1:0]   ab3_r [3];
  logic signed [DW-1:0]   ac3_r [3];
  logic signed [DW-1:0]   pq3_r [3];
  logic signed [DW-1:0]   ap3_r [3];

  // Stage 4: dot-product terms.
  logic signed [MW-1:0]   dp4_r [3];
  logic signed [MW-1:0]   tp4_r [3];
  logic signed [MW-1:0]   vp4_r [3];
  logic signed [MW-1:0]   wp4_r [3];

  // Stage 5: d = pq.n, t = ap.n, v = ac.q, wn = ab.q (w = -wn).
  logic signed [SW-1:0]   d5_r;
  logic signed [SW-1:0]   t5_r;
  logic signed [SW-1:0]   v5_r;
  logic signed [SW-1:0]   wn5_r;

  // Stage 6: range checks into the output register.
  logic signed [SW:0]     vw_sum;
  logic                   hit_nxt;
  logic                   hit_r;

  // Advance every stage together when the output register frees up.
  assign pipe_en   = !vld_r[NUM_STAGES-1] || out_tready;
  assign in_tready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_tvalid};
    end
  end

  // Unpack the five points; zero-extend so a wide z reads missing bits as zero.
  always_comb begin
    logic [PADW-1:0] ext;
    for (int p = 0; p < NUM_POINTS; p++) begin
      ext = PADW'(in_tdata[p*FIELD_W +: FIELD_W]);
      for (int k = 0; k < 3; k++) begin
        pt[p][k] = $signed(ext[k*CW +: CW]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab_nxt[k] = DW'(pt[SLOT_V2][k])    - DW'(pt[SLOT_V1][k]);
      ac_nxt[k] = DW'(pt[SLOT_V3][k])    - DW'(pt[SLOT_V1][k]);
      pq_nxt[k] = DW'(pt[SLOT_START][k]) - DW'(pt[SLOT_END][k]);
      ap_nxt[k] = DW'(pt[SLOT_START][k]) - DW'(pt[SLOT_V1][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        ab1_r[k] <= ab_nxt[k];
        ac1_r[k] <= ac_nxt[k];
        pq1_r[k] <= pq_nxt[k];
        ap1_r[k] <= ap_nxt[k];
      end
    end
  end

  // Cross-product partial products.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        npa_r[i] <= PW'(ab1_r[NEXT1[i]]) * PW'(ac1_r[NEXT2[i]]);
        npb_r[i] <= PW'(ab1_r[NEXT2[i]]) * PW'(ac1_r[NEXT1[i]]);
        qpa_r[i] <= PW'(pq1_r[NEXT1[i]]) * PW'(ap1_r[NEXT2[i]]);
        qpb_r[i] <= PW'(pq1_r[NEXT2[i]]) * PW'(ap1_r[NEXT1[i]]);
        ab2_r[i] <= ab1_r[i];
        ac2_r[i] <= ac1_r[i];
        pq2_r[i] <= pq1_r[i];
        ap2_r[i] <= ap1_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        n3_r[i]  <= NW'(npa_r[i]) - NW'(npb_r[i]);
        q3_r[i]  <= NW'(qpa_r[i]) - NW'(qpb_r[i]);
        ab3_r[i] <= ab2_r[i];
        ac3_r[i] <= ac2_r[i];
        pq3_r[i] <= pq2_r[i];
        ap3_r[i] <= ap2_r[i];
      end
    end
  end

  // Dot-product terms.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        dp4_r[i] <= MW'(pq3_r[i]) * MW'(n3_r[i]);
        tp4_r[i] <= MW'(ap3_r[i]) * MW'(n3_r[i]);
        vp4_r[i] <= MW'(ac3_r[i]) * MW'(q3_r[i]);
        wp4_r[i] <= MW'(ab3_r[i]) * MW'(q3_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d5_r  <= SW'(dp4_r[0]) + SW'(dp4_r[1]) + SW'(dp4_r[2]);
      t5_r  <= SW'(tp4_r[0]) + SW'(tp4_r[1]) + SW'(tp4_r[2]);
      v5_r  <= SW'(vp4_r[0]) + SW'(vp4_r[1]) + SW'(vp4_r[2]);
      wn5_r <= SW'(wp4_r[0]) + SW'(wp4_r[1]) + SW'(wp4_r[2]);
    end
  end

  // Hit when d > 0, 0 <= t <= d, 0 <= v <= d, w >= 0 and v + w <= d.
  assign vw_sum = (SW+1)'(v5_r) - (SW+1)'(wn5_r);

  always_comb begin
    hit_nxt = !d5_r[SW-1] && (d5_r != '0)
           && !t5_r[SW-1] && (t5_r <= d5_r)
           && !v5_r[SW-1] && (v5_r <= d5_r)
           && (wn5_r[SW-1] || (wn5_r == '0))
           && (vw_sum <= (SW+1)'(d5_r));
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_tvalid = vld_r[NUM_STAGES-1];
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, hit_r};

`ifndef NO_ASSERTIONS
  // Beats in flight change only by accepted inputs and taken results.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(vld_r) == $countones($past(vld_r))
              + $past(in_tvalid && in_tready) - $past(out_tvalid && out_tready)))
    else $error("pipeline occupancy does not match handshakes");

  // Reset empties every stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");

  // A stall freezes the valid bits and the late payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> ($stable(vld_r) && $stable(d5_r) && $stable(hit_r)))
    else $error("pipeline moved during a stall");

  // A degenerate triangle or zero-length segment never reports a hit.
  a_degenerate_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NUM_STAGES-2] && (d5_r == '0)) |-> !hit_nxt)
    else $error("hit reported with d equal to zero");
`endif

endmodule

/* dv/segment_triangle_3d_test_test.sv */
// Self-checking testbench for segment_triangle_3d_test (segment vs triangle front-face hit).
// Drives a directed table, then random queries, and checks each hit against a typed-in answer or a predictor.
// Depends on stt3d_pkg and the segment_triangle_3d_test RTL.
`timescale 1ns / 1ps

module segment_triangle_3d_test_test;
  import stt3d_pkg::*;

  localparam int unsigned COORD_W          = 16;
  localparam int unsigned CLK_HALF         = 6;
  localparam int unsigned RESET_CYCLES     = 12;
  localparam int unsigned RANDOM_PER_PHASE = 475;
  localparam int unsigned DRAIN_CYCLES     = NUM_STAGES + 4;
  localparam int unsigned PRINT_LIMIT      = 100;
  localparam longint unsigned CYCLE_LIMIT  = 200000;

  // Coordinate range of one signed COORD_W-bit component.
  localparam longint C_MIN = -(longint'(1) <<< (COORD_W - 1));
  localparam longint C_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;

  // How the expected hit of a beat is obtained: typed in, or from the predictor.
  typedef enum logic [1:0] {RES_MISS, RES_HIT, RES_PREDICT} result_kind_t;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  typedef struct {
    logic [IN_TDATA_W-1:0] beat;
    result_kind_t          kind;
  } query_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // vertex_one, vertex_two, vertex_three, start, end
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // hit, zero pad

  result_kind_t    beat_kind = RES_PREDICT;
  int unsigned     idle_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     mismatch_cnt = 0;
  int unsigned     result_idx = 0;
  longint unsigned cycle_cnt = 0;
  bit              hit_expected_q[$];
  query_row_t      directed_rows[$];

  segment_triangle_3d_test #(
    .COORD_WIDTH(COORD_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor: exact 64-bit integer geometry, no rounding anywhere.
  // ---------------------------------------------------------------------------

  // Sign-extend one coordinate; bits missing above the 48-bit field read as zero.
  function automatic longint coord(logic [FIELD_W-1:0] packed_pt, int unsigned slot);
    logic [63:0]               wide;
    logic signed [COORD_W-1:0] c;
    wide = 64'(packed_pt);
    c = wide[slot*COORD_W +: COORD_W];
    return longint'(c);
  endfunction

  function automatic vec_t unpack_pt(logic [FIELD_W-1:0] packed_pt);
    vec_t r;
    r.x = coord(packed_pt, 0);
    r.y = coord(packed_pt, 1);
    r.z = coord(packed_pt, 2);
    return r;
  endfunction

  // a + k*b; k = -1 gives the difference.
  function automatic vec_t vmad(vec_t a, vec_t b, longint k);
    vec_t r;
    r.x = a.x + k * b.x;
    r.y = a.y + k * b.y;
    r.z = a.z + k * b.z;
    return r;
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    vec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic longint vdot(vec_t a, vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic bit crosses_front_face(logic [IN_TDATA_W-1:0] beat);
    vec_t            v1, v2, v3, s, e, ab, ac, pq, nrm, ap, q;
    longint          d, t, v, w;
    longint unsigned vw_sum;
    v1 = unpack_pt(beat[SLOT_V1*FIELD_W +: FIELD_W]);
    v2 = unpack_pt(beat[SLOT_V2*FIELD_W +: FIELD_W]);
    v3 = unpack_pt(beat[SLOT_V3*FIELD_W +: FIELD_W]);
    s  = unpack_pt(beat[SLOT_START*FIELD_W +: FIELD_W]);
    e  = unpack_pt(beat[SLOT_END*FIELD_W +: FIELD_W]);
    ab  = vmad(v2, v1, -1);
    ac  = vmad(v3, v1, -1);
    pq  = vmad(s, e, -1);
    nrm = vcross(ab, ac);
    d   = vdot(pq, nrm);
    // Degenerate triangle, zero-length segment and back face all land here.
    if (d <= 0) return 1'b0;
    ap = vmad(s, v1, -1);
    t  = vdot(ap, nrm);
    if (t < 0 || t > d) return 1'b0;
    q = vcross(pq, ap);
    v = vdot(ac, q);
    if (v < 0 || v > d) return 1'b0;
    w = -vdot(ab, q);
    if (w < 0) return 1'b0;
    // Both terms are non-negative here, so the unsigned sum is exact.
    vw_sum = unsigned'(v) + unsigned'(w);
    if (vw_sum > unsigned'(d)) return 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [FIELD_W-1:0] pt(longint x, longint y, longint z);
    logic [FIELD_W-1:0] r;
    r = '0;
    r[0 +: COORD_W]         = x[COORD_W-1:0];
    r[COORD_W +: COORD_W]   = y[COORD_W-1:0];
    r[2*COORD_W +: COORD_W] = z[COORD_W-1:0];
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] pt_of(vec_t p);
    return pt(p.x, p.y, p.z);
  endfunction

  function automatic void add_row(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                  logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] s,
                                  logic [FIELD_W-1:0] e, result_kind_t kind);
    query_row_t row;
    row.beat = {e, s, c, b, a};
    row.kind = kind;
    directed_rows.push_back(row);
  endfunction

  function automatic longint rnd_coord(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  function automatic longint extreme_coord();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return 0;
      3: return -1;
      default: return rnd_coord(C_MAX);
    endcase
  endfunction

  // Mostly well-formed geometry: a random triangle, a point drawn from its
  // weighted interior, and a segment on a line through that point or a vertex.
  // The rest is raw bit noise and corner-value coordinates.
  function automatic logic [IN_TDATA_W-1:0] random_query();
    vec_t                  vtx[3];
    vec_t                  p, o, s, e;
    longint                span, wa, wb, wc, wsum, k;
    int unsigned           mode, j;
    logic [IN_TDATA_W-1:0] beat;
    mode = $urandom_range(0, 99);
    if (mode < 12) begin
      // Raw noise: every bit of every field toggles.
      for (int i = 0; i < NUM_POINTS; i++) begin
        beat[i*FIELD_W +: FIELD_W] = {16'($urandom), $urandom};
      end
      return beat;
    end
    if (mode < 22) begin
      // Corner coordinates everywhere, to stress the widest products.
      for (int i = 0; i < NUM_POINTS; i++) begin
        beat[i*FIELD_W +: FIELD_W] = pt(extreme_coord(), extreme_coord(), extreme_coord());
      end
      return beat;
    end
    span = ($urandom_range(0, 2) == 0) ? 40 : C_MAX / 4;
    for (int i = 0; i < 3; i++) begin
      vtx[i].x = rnd_coord(span);
      vtx[i].y = rnd_coord(span);
      vtx[i].z = rnd_coord(span);
    end
    wa = longint'($urandom_range(0, 6));
    wb = longint'($urandom_range(0, 6));
    wc = longint'($urandom_range(0, 6));
    if (wa + wb + wc == 0) wa = 1;
    wsum = wa + wb + wc;
    p.x = (wa * vtx[0].x + wb * vtx[1].x + wc * vtx[2].x) / wsum;
    p.y = (wa * vtx[0].y + wb * vtx[1].y + wc * vtx[2].y) / wsum;
    p.z = (wa * vtx[0].z + wb * vtx[1].z + wc * vtx[2].z) / wsum;
    o.x = rnd_coord(span);
    o.y = rnd_coord(span);
    o.z = rnd_coord(span);
    k = longint'($urandom_range(1, 2));
    j = $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      0: begin s = p;                  e = vmad(p, o, -1);      end  // start on plane
      1: begin s = vmad(p, o, 1);      e = p;                   end  // end on plane
      2: begin s = vmad(vtx[j], o, 1); e = vmad(vtx[j], o, -1); end  // through a vertex
      3: begin s = vmad(p, o, 1);      e = vmad(p, o, 2);       end  // stays on one side
      default: begin s = vmad(p, o, 1); e = vmad(p, o, -k);     end
    endcase
    return {pt_of(e), pt_of(s), pt_of(vtx[2]), pt_of(vtx[1]), pt_of(vtx[0])};
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout, receiver
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Hard stop: a hung pipeline or a lost beat ends here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result side at the rate of the current phase.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: record expectations on input beats, compare on output beats
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_LIMIT) $display("MISMATCH at result %0d: %s", result_idx, msg);
  endtask

  always @(posedge clk) begin
    bit want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (hit_expected_q.size() == 0) begin
          report_mismatch("result beat with no query outstanding");
        end else begin
          want = hit_expected_q.pop_front();
          if (out_tdata[0] !== want)
            report_mismatch($sformatf("hit %b, expected %b", out_tdata[0], want));
          if (out_tdata[OUT_TDATA_W-1:1] !== '0)
            report_mismatch($sformatf("pad bits %b not zero", out_tdata[OUT_TDATA_W-1:1]));
        end
        result_idx++;
      end
      // Typed-in rows carry their answer; everything else goes through the predictor.
      if (in_tvalid && in_tready) begin
        case (beat_kind)
          RES_HIT:  hit_expected_q.push_back(1'b1);
          RES_MISS: hit_expected_q.push_back(1'b0);
          default:  hit_expected_q.push_back(crosses_front_face(in_tdata));
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Present one beat, with random idle cycles ahead of it, and hold it until taken.
  // Returns at the falling edge after the accepting edge.
  task automatic send_beat(logic [IN_TDATA_W-1:0] beat, result_kind_t kind);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    beat_kind <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;

    // Reference triangle in the z = 0 plane, legs of 100 along x and y;
    // its normal points to +z, so the front face is hit going downward.
    // Right after reset: all points at the origin, a degenerate triangle.
    add_row(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), RES_MISS);
    // Straight through the middle, front to back.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(10, 10, 50), pt(10, 10, -50),
            RES_HIT);
    // Same line reversed: back face.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(10, 10, -50), pt(10, 10, 50),
            RES_MISS);
    // Collinear vertices: degenerate triangle.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(200, 0, 0), pt(10, 0, 50), pt(10, 0, -50),
            RES_MISS);
    // Zero-length segment lying in the triangle.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(10, 10, 0), pt(10, 10, 0),
            RES_MISS);
    // Segment stops short above the plane.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(10, 10, 50), pt(10, 10, 1),
            RES_MISS);
    // Segment entirely below the plane.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(10, 10, -1), pt(10, 10, -50),
            RES_MISS);
    // End point touches the plane.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(10, 10, 50), pt(10, 10, 0),
            RES_HIT);
    // Start point touches the plane.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(10, 10, 0), pt(10, 10, -50),
            RES_HIT);
    // Through the first vertex.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(0, 0, 50), pt(0, 0, -50), RES_HIT);
    // Through the second vertex.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(100, 0, 50), pt(100, 0, -50),
            RES_HIT);
    // On the hypotenuse, then one step outside it.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(50, 50, 50), pt(50, 50, -50),
            RES_HIT);
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(51, 50, 50), pt(51, 50, -50),
            RES_MISS);
    // One step outside the y-axis leg.
    add_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(-1, 10, 50), pt(-1, 10, -50),
            RES_MISS);
    // Full-range triangle and segment, through the first vertex.
    add_row(pt(C_MIN, C_MIN, 0), pt(C_MAX, C_MIN, 0), pt(C_MIN, C_MAX, 0),
            pt(C_MIN, C_MIN, C_MAX), pt(C_MIN, C_MIN, C_MIN), RES_HIT);
    // All bits set: every point at (-1,-1,-1).
    add_row({FIELD_W{1'b1}}, {FIELD_W{1'b1}}, {FIELD_W{1'b1}}, {FIELD_W{1'b1}},
            {FIELD_W{1'b1}}, RES_MISS);
    // All points at the positive corner.
    add_row(pt(C_MAX, C_MAX, C_MAX), pt(C_MAX, C_MAX, C_MAX), pt(C_MAX, C_MAX, C_MAX),
            pt(C_MAX, C_MAX, C_MAX), pt(C_MAX, C_MAX, C_MAX), RES_MISS);
    // Mixed corners, both directions: widest intermediate values.
    add_row(pt(C_MAX, C_MIN, C_MAX), pt(C_MIN, C_MAX, C_MIN), pt(C_MAX, C_MAX, C_MIN),
            pt(C_MIN, C_MIN, C_MAX), pt(C_MAX, C_MAX, C_MIN), RES_PREDICT);
    add_row(pt(C_MAX, C_MIN, C_MAX), pt(C_MIN, C_MAX, C_MIN), pt(C_MAX, C_MAX, C_MIN),
            pt(C_MAX, C_MAX, C_MIN), pt(C_MIN, C_MIN, C_MAX), RES_PREDICT);
    add_row(pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MIN, C_MIN), pt(C_MIN, C_MAX, C_MIN),
            pt(C_MIN, C_MIN, C_MAX), pt(C_MAX, C_MAX, C_MIN), RES_PREDICT);
    // Alternating bit patterns.
    add_row(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_5555_AAAA,
            48'h5555_AAAA_5555, 48'hAAAA_AAAA_5555, RES_PREDICT);
    add_row(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_AAAA_5555,
            48'hAAAA_5555_AAAA, 48'h5555_5555_AAAA, RES_PREDICT);
    // Tilted triangle crossed both ways.
    add_row(pt(-300, 200, 17), pt(450, -120, 90), pt(30, 500, -260), pt(40, 60, 400),
            pt(90, 110, -380), RES_PREDICT);
    add_row(pt(-300, 200, 17), pt(450, -120, 90), pt(30, 500, -260), pt(90, 110, -380),
            pt(40, 60, 400), RES_PREDICT);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at full rate.
    foreach (directed_rows[i]) send_beat(directed_rows[i].beat, directed_rows[i].kind);

    // Random queries through the idle and stall phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      repeat (RANDOM_PER_PHASE) send_beat(random_query(), RES_PREDICT);
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every outstanding result, then let the pipeline settle.
    while (hit_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
